// File: sv/olid_pkg.sv
// Package with the shared sizes, codes and control types of the ordered list.
package olid_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W    = 7;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_DELETE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] tgt;
    logic [VAL_W-1:0] val;
  } olid_ctl_t;

endpackage

// File: sv/ordered_list_insert_delete.sv
// Ordered list with positional insert and delete, built as a chain of cells.
// A result word appears in the output register in the cycle after its input is taken.
// Throughput: one word per cycle while the output is not held; every cell shifts in parallel in the same cycle.
// The output register and the next input share a cycle, so the input stalls only on back-pressure.
// Reset clears the element count and the output valid; element contents are not cleared.
module ordered_list_insert_delete (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // position [6:0], value [38:7], zero [39]
  input  logic [olid_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // action [0]
  input  logic                                s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // removed_value [31:0], length [38:32], zero [39]
  output logic [olid_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  // status [1:0]
  output logic [1:0]                          m_axis_tuser_o
);

  logic [olid_pkg::POS_W-1:0] position;
  logic [olid_pkg::VAL_W-1:0] value;
  logic                       accept;

  logic [olid_pkg::CNT_W-1:0] count_q;
  logic [olid_pkg::CNT_W-1:0] count_d;
  logic                       out_valid_q;
  olid_pkg::status_e          status_q;
  olid_pkg::status_e          status_d;
  logic [olid_pkg::VAL_W-1:0] removed_q;
  logic [olid_pkg::VAL_W-1:0] removed_d;

  logic [olid_pkg::CMP_W-1:0] pos_ext;
  logic [olid_pkg::CMP_W-1:0] cnt_ext;
  logic                       ins_ok;
  logic                       del_ok;
  olid_pkg::olid_ctl_t        ctl;

  logic [olid_pkg::VAL_W-1:0] cell_val [olid_pkg::CAPACITY];
  logic [olid_pkg::VAL_W-1:0] cell_hit [olid_pkg::CAPACITY];
  logic [olid_pkg::VAL_W-1:0] hit_any;

  assign position = s_axis_tdata_i[olid_pkg::POS_W-1:0];
  assign value    = s_axis_tdata_i[olid_pkg::POS_W +: olid_pkg::VAL_W];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign pos_ext = olid_pkg::CMP_W'(position);
  assign cnt_ext = olid_pkg::CMP_W'(count_q);

  always_comb begin
    status_d = olid_pkg::ST_OK;
    ins_ok   = 1'b0;
    del_ok   = 1'b0;
    count_d  = count_q;
    unique case (olid_pkg::action_e'(s_axis_tuser_i))
      olid_pkg::ACT_INSERT: begin
        if (pos_ext == '0 || pos_ext > cnt_ext + olid_pkg::CMP_W'(1)) begin
          status_d = olid_pkg::ST_BAD_POS;
        end else if (cnt_ext >= olid_pkg::CMP_W'(olid_pkg::CAPACITY)) begin
          status_d = olid_pkg::ST_FULL;
        end else begin
          ins_ok  = 1'b1;
          count_d = count_q + olid_pkg::CNT_W'(1);
        end
      end
      olid_pkg::ACT_DELETE: begin
        if (pos_ext == '0 || pos_ext > cnt_ext) begin
          status_d = olid_pkg::ST_BAD_POS;
        end else begin
          del_ok  = 1'b1;
          count_d = count_q - olid_pkg::CNT_W'(1);
        end
      end
      default: begin
        status_d = olid_pkg::ST_BAD_POS;
      end
    endcase
  end

  // The target index is only meaningful when the position passed its check.
  assign ctl.ins = accept && ins_ok;
  assign ctl.del = accept && del_ok;
  assign ctl.tgt = olid_pkg::IDX_W'(pos_ext - olid_pkg::CMP_W'(1));
  assign ctl.val = value;

  for (genvar k = 0; k < olid_pkg::CAPACITY; k++) begin : g_cell
    logic [olid_pkg::VAL_W-1:0] left;
    logic [olid_pkg::VAL_W-1:0] right;
    if (k == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_val[k-1];
    end
    if (k == olid_pkg::CAPACITY - 1) begin : g_last
      assign right = cell_val[k];
    end else begin : g_mid_r
      assign right = cell_val[k+1];
    end
    olid_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .cell_idx_i (olid_pkg::IDX_W'(k)),
      .left_i     (left),
      .right_i    (right),
      .value_o    (cell_val[k]),
      .hit_o      (cell_hit[k])
    );
  end

  // Only the addressed cell drives a nonzero hit, so an OR picks it out.
  always_comb begin
    hit_any = '0;
    for (int k = 0; k < olid_pkg::CAPACITY; k++) begin
      hit_any = hit_any | cell_hit[k];
    end
  end

  assign removed_d = del_ok ? hit_any : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      removed_q <= removed_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tdata_o  = {1'b0, olid_pkg::LEN_W'(count_q), removed_q};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= olid_pkg::CNT_W'(olid_pkg::CAPACITY))
    else $error("element count above capacity");

  a_accept_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid_o)
    else $error("accepted word produced no result");

  a_len_tracks_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[olid_pkg::VAL_W +: olid_pkg::LEN_W]
                        == olid_pkg::LEN_W'(count_q))
    else $error("reported length differs from element count");

  a_error_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status_d != olid_pkg::ST_OK) |=> count_q == $past(count_q))
    else $error("rejected word changed the element count");
`endif

endmodule

// File: sv/olid_cell.sv
// One storage cell of the list chain: holds one element and shifts with its neighbors.
module olid_cell (
  input  logic                              clk_i,
  input  olid_pkg::olid_ctl_t               ctl_i,
  input  logic [olid_pkg::IDX_W-1:0]        cell_idx_i,
  input  logic [olid_pkg::VAL_W-1:0]        left_i,
  input  logic [olid_pkg::VAL_W-1:0]        right_i,
  output logic [olid_pkg::VAL_W-1:0]        value_o,
  output logic [olid_pkg::VAL_W-1:0]        hit_o
);

  logic [olid_pkg::VAL_W-1:0] value_q;
  logic [olid_pkg::VAL_W-1:0] value_d;
  logic                       above;
  logic                       at;

  assign above = cell_idx_i > ctl_i.tgt;
  assign at    = cell_idx_i == ctl_i.tgt;

  // Insert writes the new value into the target and moves everything above it
  // up by one; delete pulls the target and everything above it down by one.
  always_comb begin
    value_d = value_q;
    if (ctl_i.ins) begin
      if (above) begin
        value_d = left_i;
      end else if (at) begin
        value_d = ctl_i.val;
      end
    end else if (ctl_i.del) begin
      if (above || at) begin
        value_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign hit_o   = at ? value_q : '0;

endmodule
